// ----- rtl/assert_macros.svh -----
// Assertion macros used by the heightmap normal generator controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/hmng_pkg.sv -----
// Package: types, constants and register indexes of the heightmap normal generator
`default_nettype none
package hmng_pkg;

  localparam int MAX_POINTS_DEF  = 257;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam logic [15:0] ONE_Q14       = 16'd16384;
  localparam logic [15:0] SPACING_RESET = 16'd256;
  localparam logic [8:0]  POINTS_RESET  = 9'd257;

  typedef enum logic [1:0] {
    CFG_SMOOTH  = 2'd0,
    CFG_SPACING = 2'd1,
    CFG_POINTS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               tile_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         vertex_row;
    logic [7:0]         vertex_col;
    logic               last_of_tile;
  } out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } nrm_t;

  typedef struct packed {
    logic       accept;
    logic       update;
    logic       sq;
    logic       sum;
    logic       zero;
    logic       div_init;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       store;
    logic       fin;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic s_zero;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/hmng_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module hmng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hmng_ctrl.sv -----
// Controller: sequences accept, squaring, division and root per normal component
`default_nettype none
`include "assert_macros.svh"
module hmng_ctrl
  import hmng_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_SQ    = 10'b0000000100,
    S_SUM   = 10'b0000001000,
    S_DINIT = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_QINIT = 10'b0001000000,
    S_SQRT  = 10'b0010000000,
    S_STORE = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  localparam logic [4:0] DIV_LAST  = 5'd30;
  localparam logic [4:0] SQRT_LAST = 5'd15;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    cmd       = '0;
    cmd.comp  = comp_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        cmd.update = 1'b1;
        comp_nxt   = 2'd0;
        state_nxt  = sts.produce ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (comp_r == 2'd2) begin
          comp_nxt  = 2'd0;
          state_nxt = S_SUM;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        if (sts.s_zero) begin
          cmd.zero  = 1'b1;
          comp_nxt  = 2'd0;
          state_nxt = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_QINIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_QINIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_STORE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (comp_r == 2'd2) begin
          comp_nxt  = 2'd0;
          state_nxt = S_FIN;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_DINIT;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

  `ASSERT_CLK(a_accept_to_read, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_RD), "accepted transaction did not move to read")
  `ASSERT_NEVER(a_comp_range, clk, rst_n, comp_r == 2'd3, "component index out of range")
  `ASSERT_NEVER(a_sqrt_count, clk, rst_n, (state_r == S_SQRT) && (cnt_r > SQRT_LAST), "root iteration count overrun")
  `ASSERT_CLK(a_fin_free, clk, rst_n, cmd.fin |-> !sts.out_busy, "result overwrote a waiting output")

endmodule
`default_nettype wire

// ----- rtl/hmng_dp.sv -----
// Datapath: config registers, row stores, squaring, divider, root and output register
`default_nettype none
module hmng_dp
  import hmng_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_t         in_data,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data
);

  localparam int HW  = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NAW = $clog2(MAX_POINTS - 1);

  // configuration
  logic        smooth_r;
  logic [15:0] spacing_r;
  logic [8:0]  pts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r  <= 1'b0;
      spacing_r <= SPACING_RESET;
      pts_r     <= POINTS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SMOOTH:  smooth_r  <= cfg_data[0];
        CFG_SPACING: spacing_r <= cfg_data;
        CFG_POINTS:  pts_r     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [PW-1:0] p_eff, pm1, pm2;
  always_comb begin
    if (32'(pts_r) < 3) begin
      p_eff = PW'(3);
    end else if (32'(pts_r) > MAX_POINTS) begin
      p_eff = PW'(MAX_POINTS);
    end else begin
      p_eff = PW'(pts_r);
    end
    pm1 = p_eff - PW'(1);
    pm2 = p_eff - PW'(2);
  end

  // sample position and neighbor heights
  logic [PW-1:0]        row_r, col_r, cur_row_r, cur_col_r;
  logic signed [HW-1:0] h_r, prev_h_r, prev_row_h_r;
  logic [PW-1:0]        row_in, col_in;
  logic signed [HW-1:0] h_in;

  assign row_in = in_data.tile_start ? '0 : row_r;
  assign col_in = in_data.tile_start ? '0 : col_r;
  assign h_in   = in_data.height[HW-1:0];

  logic [HW-1:0]  hram_q;
  logic [47:0]    nram_q;
  nrm_t           own_r, left_r, above_r;
  logic [PW-1:0]  vr, vc;

  assign vr = cur_row_r - PW'(1);
  assign vc = cur_col_r - PW'(1);

  hmng_ram #(.WIDTH(HW), .DEPTH(MAX_POINTS)) u_hram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (cur_col_r[AW-1:0]),
    .wdata (h_r),
    .re    (cmd.accept),
    .raddr (col_in[AW-1:0]),
    .rdata (hram_q)
  );

  logic [PW-1:0] col_m1;
  assign col_m1 = col_in - PW'(1);

  hmng_ram #(.WIDTH(48), .DEPTH(MAX_POINTS - 1)) u_nram (
    .clk   (clk),
    .we    (cmd.fin),
    .waddr (vc[NAW-1:0]),
    .wdata (own_r),
    .re    (cmd.accept),
    .raddr (col_m1[NAW-1:0]),
    .rdata (nram_q)
  );

  logic produce;
  assign produce = (cur_row_r != '0) && (cur_col_r != '0) &&
                   (cur_row_r <= pm1) && (cur_col_r <= pm1);

  logic signed [HW:0] dr, du;
  logic [HW:0]        dr_abs, du_abs;
  assign dr     = {hram_q[HW-1], hram_q} - {prev_row_h_r[HW-1], prev_row_h_r};
  assign du     = {prev_h_r[HW-1], prev_h_r} - {prev_row_h_r[HW-1], prev_row_h_r};
  assign dr_abs = dr[HW] ? ((HW+1)'(0) - dr) : dr;
  assign du_abs = du[HW] ? ((HW+1)'(0) - du) : du;

  logic [15:0] mag_r [3];
  logic        neg_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      prev_h_r     <= '0;
      prev_row_h_r <= '0;
    end else begin
      if (cmd.accept) begin
        cur_row_r <= row_in;
        cur_col_r <= col_in;
        h_r       <= h_in;
      end
      if (cmd.update) begin
        mag_r[0]     <= 16'(dr_abs);
        mag_r[1]     <= spacing_r;
        mag_r[2]     <= 16'(du_abs);
        neg_r[0]     <= !dr[HW] && (dr != '0);
        neg_r[1]     <= 1'b0;
        neg_r[2]     <= !du[HW] && (du != '0);
        above_r      <= nram_q;
        prev_row_h_r <= hram_q;
        prev_h_r     <= h_r;
        if (cur_col_r >= pm1) begin
          col_r <= '0;
          row_r <= (cur_row_r >= pm1) ? '0 : cur_row_r + PW'(1);
        end else begin
          row_r <= cur_row_r;
          col_r <= cur_col_r + PW'(1);
        end
      end
    end
  end

  // squares, sum, long division, integer root
  logic [31:0] sq_r [3];
  logic [33:0] s_r;
  logic [33:0] rem_r;
  logic        nbit_r;
  logic [30:0] q_r;
  logic [30:0] op_r, res_r, one_r;

  logic [34:0] div_cat;
  logic        div_ge;
  logic [31:0] trial;
  logic        sq_ge;
  logic [16:0] m_rnd;
  logic [15:0] m_val;

  assign div_cat = {rem_r, nbit_r};
  assign div_ge  = div_cat >= {1'b0, s_r};
  assign trial   = {1'b0, res_r} + {1'b0, one_r};
  assign sq_ge   = {1'b0, op_r} >= trial;
  assign m_rnd   = {1'b0, res_r[15:0]} + 17'd1;
  assign m_val   = m_rnd[16:1];

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sq_r[cmd.comp] <= mag_r[cmd.comp] * mag_r[cmd.comp];
    end
    if (cmd.sum) begin
      s_r <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
    end
    // quotient of sq * 2^30 / s; the low 30 bits of the dividend are zero
    if (cmd.div_init) begin
      rem_r  <= 34'(sq_r[cmd.comp][31:1]);
      nbit_r <= sq_r[cmd.comp][0];
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? 34'(div_cat - {1'b0, s_r}) : div_cat[33:0];
      nbit_r <= 1'b0;
      q_r    <= {q_r[29:0], div_ge};
    end
    if (cmd.sqrt_init) begin
      op_r  <= q_r;
      res_r <= '0;
      one_r <= 31'h4000_0000;
    end else if (cmd.sqrt_step) begin
      if (sq_ge) begin
        op_r  <= op_r - trial[30:0];
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r <= one_r >> 2;
    end
    // rounded magnitude is (isqrt + 1) / 2
    if (cmd.store) begin
      case (cmd.comp)
        2'd0:    own_r.x <= neg_r[0] ? (16'd0 - m_val) : m_val;
        2'd1:    own_r.y <= neg_r[1] ? (16'd0 - m_val) : m_val;
        default: own_r.z <= neg_r[2] ? (16'd0 - m_val) : m_val;
      endcase
    end else if (cmd.zero) begin
      own_r <= '{x: 16'sd0, y: ONE_Q14, z: 16'sd0};
    end
  end

  // neighbor selection and output register
  logic re_v, ce_v;
  nrm_t use_n;
  assign re_v = !vr[0];
  assign ce_v = !vc[0];

  always_comb begin
    use_n = own_r;
    if (smooth_r) begin
      if (re_v && !ce_v) begin
        use_n = (vr == '0) ? left_r : above_r;
      end else if (!re_v && ce_v) begin
        use_n = (vc == '0) ? above_r : left_r;
      end
    end
  end

  logic out_valid_r;
  out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
        left_r      <= own_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r.normal_x     <= use_n.x;
      out_r.normal_y     <= use_n.y;
      out_r.normal_z     <= use_n.z;
      out_r.vertex_row   <= 8'(vr);
      out_r.vertex_col   <= 8'(vc);
      out_r.last_of_tile <= (vr == pm2) && (vc == pm2);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.produce  = produce;
  assign sts.s_zero   = (s_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule
`default_nettype wire

// ----- rtl/heightmap_normal_generator_unit.sv -----
// Top level of the heightmap normal generator: controller plus datapath
//
//  channel | ports                                  | direction
//  input   | in_valid, in_ready, in_data            | height sample in
//  result  | out_valid, out_ready, out_data         | vertex normal out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// A sample without a result returns to idle after the read. One with a result runs
// read, 3 squares, sum, then per component a 31-step long division and a 16-step
// integer root in one shared unit, then loads the output; when dr, spacing and du are
// all zero it goes from the sum straight to loading the output.
// rst_n is synchronous; it clears counters, config and the output valid.
// A full output register holds the next result in its last state until taken.
`default_nettype none
module heightmap_normal_generator_unit
  import hmng_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hmng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hmng_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
